/* design/tscu_pkg.sv */
// Package for the Taylor sine, cosine and tangent unit.
// Holds the working widths, the mode codes, the pipeline structs and the
// saturation helper. Depends on nothing.
package tscu_pkg;

   // Defaults for the top-level parameters
   localparam int SERIES_TERMS_DEF  = 10;
   localparam int FRACTION_BITS_DEF = 24;

   // Port field widths
   localparam int ANGLE_W = 32;
   localparam int VALUE_W = 32;

   // Working format: 32 fraction bits
   localparam int WORK_BITS = 32;
   localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;

   // Reduction width, covers 2*pi at 30 fraction bits and its multiples
   localparam int RED_W = 34;
   // Reduced angle, its square, one series term and the running sum
   localparam int X_W   = 35;
   localparam int X2_W  = 38;
   localparam int T_W   = 40;
   localparam int SUM_W = T_W + 1;
   // Product term*x^2 after rounding, and the reciprocal used per factorial step
   localparam int N_W         = 46;
   localparam int M_W         = 56;
   localparam int RECIP_SHIFT = 56;
   // Register stages in one series cell
   localparam int CELL_STAGES = 5;
   // Tangent quotient: 32 bits plus an overflow bit; one divider cell per bit
   localparam int QUO_W = 33;
   localparam int DIV_W = SUM_W + QUO_W;

   typedef enum logic [1:0] {
      MODE_SIN = 2'd0,
      MODE_COS = 2'd1,
      MODE_TAN = 2'd2
   } mode_type;

   // Control that travels with each request
   typedef struct packed {
      logic     valid;
      mode_type mode;
   } ctrl_type;

   // One result
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               dz;
      logic               sat;
   } rsp_type;

   // Apply a sign to a magnitude and clip to the signed 32-bit range
   function automatic rsp_type saturate(input logic [SUM_W-1:0] mag, input logic neg);
      rsp_type            r;
      logic [SUM_W-1:0]   negm;
      r.dz  = 1'b0;
      r.sat = 1'b0;
      negm  = '0;
      if (neg) begin
         if (mag > SUM_W'(33'h0_8000_0000)) begin
            r.value = 32'h8000_0000;
            r.sat   = 1'b1;
         end else begin
            negm    = SUM_W'(0) - mag;
            r.value = negm[VALUE_W-1:0];
         end
      end else begin
         if (mag > SUM_W'(33'h0_7FFF_FFFF)) begin
            r.value = 32'h7FFF_FFFF;
            r.sat   = 1'b1;
         end else begin
            r.value = mag[VALUE_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

/* design/taylor_sin_cos_tan_unit.sv */
// Top level of the Taylor sine, cosine and tangent unit.
// Uses tscu_pkg, tscu_reduce, tscu_term_cell and tscu_div_cell.
//
//   channel | dir | ports              | contents
//   --------+-----+--------------------+------------------------------------------
//   req     | in  | req_tvalid/tready  | tdata: angle (Q8.24); tuser: mode
//   rsp     | out | rsp_tvalid/tready  | tdata: value (Q8.24); tuser: dz, saturated
//
// One request per cycle while req_tready is high; every request passes the reduction
// steps, STEPS = max(1, 29 - FRACTION_BITS), five stages per series cell, one finish
// stage, 33 divider cells and the output register.
// Reset is synchronous and clears the valid, control and side registers, not the data path; no clearing pass.
// A result held at the output leaves the pipe running; req_tready drops once the
// skid register behind the output also fills.
module taylor_sin_cos_tan_unit #(
   parameter int SERIES_TERMS  = tscu_pkg::SERIES_TERMS_DEF,
   parameter int FRACTION_BITS = tscu_pkg::FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [1:0]  rsp_tuser    // [0] divide_by_zero, [1] saturated
);

   localparam int X_W   = tscu_pkg::X_W;
   localparam int X2_W  = tscu_pkg::X2_W;
   localparam int T_W   = tscu_pkg::T_W;
   localparam int SUM_W = tscu_pkg::SUM_W;
   localparam int DIV_W = tscu_pkg::DIV_W;
   localparam int QUO_W = tscu_pkg::QUO_W;
   localparam int WB    = tscu_pkg::WORK_BITS;
   localparam int CHAIN_LAT = SERIES_TERMS * tscu_pkg::CELL_STAGES;
   localparam int DIV_STEPS = QUO_W;

   typedef struct packed {
      logic               valid;
      tscu_pkg::mode_type mode;
      logic               neg;
      tscu_pkg::rsp_type  res;
   } side_type;

   logic                en;
   tscu_pkg::ctrl_type  req_ctrl;
   tscu_pkg::ctrl_type  red_ctrl;
   logic [X_W-1:0]      red_x;
   logic [X2_W-1:0]     red_x2;

   logic [X2_W-1:0]         sx2 [SERIES_TERMS+1];
   logic [T_W-1:0]          st  [SERIES_TERMS+1];
   logic signed [SUM_W-1:0] ss  [SERIES_TERMS+1];
   logic [X2_W-1:0]         cx2 [SERIES_TERMS+1];
   logic [T_W-1:0]          ct  [SERIES_TERMS+1];
   logic signed [SUM_W-1:0] cs  [SERIES_TERMS+1];
   tscu_pkg::ctrl_type      cl_ff [CHAIN_LAT];

   side_type            side_in;
   side_type            side_ff [DIV_STEPS+1];
   logic [DIV_W-1:0]    rem0_in;
   logic [DIV_W-1:0]    rem0_ff;
   logic [SUM_W-1:0]    den0_in;
   logic [SUM_W-1:0]    den0_ff;
   logic [DIV_W-1:0]    rem [DIV_STEPS+1];
   logic [SUM_W-1:0]    den [DIV_STEPS+1];
   logic [QUO_W-1:0]    quo [DIV_STEPS+1];

   tscu_pkg::rsp_type   fin;
   logic                push;
   logic                pop;
   logic                load_out;
   logic                load_sk;
   logic                out_from_sk;
   logic                out_v_ff;
   logic                out_v_in;
   logic                sk_v_ff;
   logic                sk_v_in;
   tscu_pkg::rsp_type   out_ff;
   tscu_pkg::rsp_type   sk_ff;

   // Hold the whole pipe only while the skid register is full
   assign en         = !sk_v_ff;
   assign req_tready = en;
   assign req_ctrl.valid = req_tvalid;
   assign req_ctrl.mode  = tscu_pkg::mode_type'(req_tuser);

   tscu_reduce #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_reduce (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctrl  (req_ctrl),
      .in_angle ($signed(req_tdata)),
      .out_ctrl (red_ctrl),
      .out_x    (red_x),
      .out_x2   (red_x2)
   );

   // Seed the sine chain with x and the cosine chain with 1.0
   assign sx2[0] = red_x2;
   assign st[0]  = T_W'(red_x);
   assign ss[0]  = '0;
   assign cx2[0] = red_x2;
   assign ct[0]  = T_W'(1) << WB;
   assign cs[0]  = SUM_W'(1) << WB;

   for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_terms
      tscu_term_cell #(
         .TERM   (g + 1),
         .COSINE (1'b0)
      ) u_sin (
         .clock (clock),
         .en    (en),
         .x2_i  (sx2[g]),
         .t_i   (st[g]),
         .sum_i (ss[g]),
         .x2_o  (sx2[g+1]),
         .t_o   (st[g+1]),
         .sum_o (ss[g+1])
      );
      tscu_term_cell #(
         .TERM   (g + 1),
         .COSINE (1'b1)
      ) u_cos (
         .clock (clock),
         .en    (en),
         .x2_i  (cx2[g]),
         .t_i   (ct[g]),
         .sum_i (cs[g]),
         .x2_o  (cx2[g+1]),
         .t_o   (ct[g+1]),
         .sum_o (cs[g+1])
      );
   end

   // Carry the request control alongside the series chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CHAIN_LAT; j++) cl_ff[j] <= '0;
      end else if (en) begin
         cl_ff[0] <= red_ctrl;
         for (int j = 1; j < CHAIN_LAT; j++) cl_ff[j] <= cl_ff[j-1];
      end
   end

   // Round sine or cosine, and set up the tangent division
   always_comb begin
      logic signed [SUM_W-1:0] s;
      logic signed [SUM_W-1:0] c;
      logic signed [SUM_W-1:0] sel;
      logic [SUM_W-1:0]        mag;
      logic [SUM_W:0]          rnd;
      logic [SUM_W-1:0]        sm;
      logic [SUM_W-1:0]        cm;
      s   = ss[SERIES_TERMS];
      c   = cs[SERIES_TERMS];
      sel = (cl_ff[CHAIN_LAT-1].mode == tscu_pkg::MODE_COS) ? c : s;
      mag = sel[SUM_W-1] ? SUM_W'(0) - sel : sel;
      rnd = ((SUM_W+1)'(mag) + ((SUM_W+1)'(1) << (WB - FRACTION_BITS - 1)))
            >> (WB - FRACTION_BITS);
      sm  = s[SUM_W-1] ? SUM_W'(0) - s : s;
      cm  = c[SUM_W-1] ? SUM_W'(0) - c : c;

      side_in.valid = cl_ff[CHAIN_LAT-1].valid;
      side_in.mode  = cl_ff[CHAIN_LAT-1].mode;
      side_in.neg   = s[SUM_W-1] ^ c[SUM_W-1];
      side_in.res   = tscu_pkg::saturate(rnd[SUM_W-1:0], sel[SUM_W-1]);
      side_in.res.dz = (c == '0);
      rem0_in = (DIV_W'(sm) << FRACTION_BITS) + DIV_W'(cm >> 1);
      den0_in = cm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_STEPS; j++) side_ff[j] <= '0;
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int j = 1; j <= DIV_STEPS; j++) side_ff[j] <= side_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff <= rem0_in;
         den0_ff <= den0_in;
      end
   end

   assign rem[0] = rem0_ff;
   assign den[0] = den0_ff;
   assign quo[0] = '0;

   // Quotient bits from the overflow bit down to bit zero
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      tscu_div_cell #(
         .STEP (DIV_STEPS - 1 - k)
      ) u_div (
         .clock (clock),
         .en    (en),
         .rem_i (rem[k]),
         .den_i (den[k]),
         .quo_i (quo[k]),
         .rem_o (rem[k+1]),
         .den_o (den[k+1]),
         .quo_o (quo[k+1])
      );
   end

   // Pick the result for the mode
   always_comb begin
      side_type e;
      e = side_ff[DIV_STEPS];
      fin = '0;
      case (e.mode) inside
         tscu_pkg::MODE_SIN, tscu_pkg::MODE_COS: begin
            fin     = e.res;
            fin.dz  = 1'b0;
         end
         tscu_pkg::MODE_TAN: begin
            if (e.res.dz) begin
               fin.dz = 1'b1;
            end else begin
               fin = tscu_pkg::saturate(SUM_W'(quo[DIV_STEPS]), e.neg);
            end
         end
         default: fin = '0;
      endcase
   end

   // Output register with a skid register behind it
   always_comb begin
      pop         = out_v_ff && rsp_tready;
      push        = en && side_ff[DIV_STEPS].valid;
      out_v_in    = out_v_ff;
      sk_v_in     = sk_v_ff;
      load_out    = 1'b0;
      load_sk     = 1'b0;
      out_from_sk = 1'b0;
      if (sk_v_ff) begin
         if (pop) begin
            out_from_sk = 1'b1;
            sk_v_in     = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            load_out = 1'b1;
            out_v_in = 1'b1;
         end else begin
            load_sk = 1'b1;
            sk_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) out_ff <= fin;
      if (out_from_sk) out_ff <= sk_ff;
      if (load_sk) sk_ff <= fin;
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = out_ff.value;
   assign rsp_tuser[0] = out_ff.dz;
   assign rsp_tuser[1] = out_ff.sat;

   // The skid register only holds a request while the output register is full
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid register holds a request with the output empty");

   // The skid register fills only after a stalled output
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_v_ff) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("skid register filled without an output stall");

   // A zero cosine gives a plain zero
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0 && !rsp_tuser[1])
      else $error("divide flag with nonzero value or saturation");

   // Clipping lands on a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         (rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000))
      else $error("saturated value off the range limits");

endmodule

/* design/tscu_reduce.sv */
// Front end of the unit: brings the angle into [0, 2*pi] by restoring
// subtraction of 2*pi multiples, moves it to the working format, squares it.
// Depends on tscu_pkg.
module tscu_reduce #(
   parameter int FRACTION_BITS = tscu_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  tscu_pkg::ctrl_type               in_ctrl,
   input  logic signed [tscu_pkg::ANGLE_W-1:0] in_angle,
   output tscu_pkg::ctrl_type               out_ctrl,
   output logic [tscu_pkg::X_W-1:0]         out_x,
   output logic [tscu_pkg::X2_W-1:0]        out_x2
);

   localparam int RED_W = tscu_pkg::RED_W;
   localparam int X_W   = tscu_pkg::X_W;
   localparam int X2_W  = tscu_pkg::X2_W;
   localparam int WB    = tscu_pkg::WORK_BITS;
   // 2*pi rounded to FRACTION_BITS
   localparam logic [63:0] TP64 =
      (tscu_pkg::TWO_PI_Q60 + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS);
   localparam logic [RED_W-1:0] TP = TP64[RED_W-1:0];
   // Quotient bits needed to cover the whole angle range
   localparam int STEPS = (FRACTION_BITS < 28) ? (29 - FRACTION_BITS) : 1;
   localparam int XL    = (X_W + 1) / 2;
   localparam int XH    = X_W - XL;
   localparam int SQ_W  = 2 * X_W;

   typedef enum logic [1:0] {
      CLS_IN    = 2'd0,
      CLS_ABOVE = 2'd1,
      CLS_BELOW = 2'd2
   } cls_type;

   tscu_pkg::ctrl_type    ctl_ff [STEPS+1];
   cls_type               cls_ff [STEPS+1];
   logic [RED_W-1:0]      u_ff   [STEPS+1];
   logic [RED_W-1:0]      u_in   [STEPS+1];
   cls_type               cls0_in;

   tscu_pkg::ctrl_type    ctlx_ff;
   logic [X_W-1:0]        x_ff;
   logic [X_W-1:0]        x_in;

   tscu_pkg::ctrl_type    ctls_ff;
   logic [X_W-1:0]        xs_ff;
   logic [2*XL-1:0]       pll_ff;
   logic [XL+XH-1:0]      plh_ff;
   logic [2*XH-1:0]       phh_ff;

   tscu_pkg::ctrl_type    ctlq_ff;
   logic [X_W-1:0]        xq_ff;
   logic [X2_W-1:0]       x2_ff;
   logic [X2_W-1:0]       x2_in;

   // Classify the angle and form the operand of the reduction, then take
   // one restoring step per stage, largest multiple first
   always_comb begin
      logic signed [RED_W-1:0] a_s;
      logic [RED_W-1:0]        lim;
      a_s = RED_W'(in_angle);
      if (a_s > $signed(TP)) begin
         cls0_in = CLS_ABOVE;
         u_in[0] = a_s - RED_W'(1);
      end else if (a_s < 0) begin
         cls0_in = CLS_BELOW;
         u_in[0] = RED_W'(0) - a_s;
      end else begin
         cls0_in = CLS_IN;
         u_in[0] = a_s;
      end
      for (int j = 0; j < STEPS; j++) begin
         lim = TP << (STEPS - 1 - j);
         if (cls_ff[j] != CLS_IN && u_ff[j] >= lim) begin
            u_in[j+1] = u_ff[j] - lim;
         end else begin
            u_in[j+1] = u_ff[j];
         end
      end
   end

   // Undo the offset of each class and move to 32 fraction bits
   always_comb begin
      logic [RED_W-1:0] a_red;
      case (cls_ff[STEPS])
         CLS_ABOVE: a_red = u_ff[STEPS] + RED_W'(1);
         CLS_BELOW: a_red = (u_ff[STEPS] == '0) ? '0 : TP - u_ff[STEPS];
         default:   a_red = u_ff[STEPS];
      endcase
      x_in = {{(X_W-RED_W){1'b0}}, a_red} << (WB - FRACTION_BITS);
   end

   // Sum the partial products of x*x and round at 32 bits
   always_comb begin
      logic [SQ_W:0] full;
      full = (SQ_W+1)'(pll_ff) + ((SQ_W+1)'(plh_ff) << (XL + 1))
           + ((SQ_W+1)'(phh_ff) << (2 * XL)) + ((SQ_W+1)'(1) << (WB - 1));
      x2_in = full[WB +: X2_W];
   end

   // Control valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= STEPS; j++) ctl_ff[j] <= '0;
         ctlx_ff <= '0;
         ctls_ff <= '0;
         ctlq_ff <= '0;
      end else if (en) begin
         ctl_ff[0] <= in_ctrl;
         for (int j = 0; j < STEPS; j++) ctl_ff[j+1] <= ctl_ff[j];
         ctlx_ff <= ctl_ff[STEPS];
         ctls_ff <= ctlx_ff;
         ctlq_ff <= ctls_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         cls_ff[0] <= cls0_in;
         for (int j = 0; j < STEPS; j++) cls_ff[j+1] <= cls_ff[j];
         for (int j = 0; j <= STEPS; j++) u_ff[j] <= u_in[j];
         x_ff   <= x_in;
         xs_ff  <= x_ff;
         pll_ff <= x_ff[XL-1:0] * x_ff[XL-1:0];
         plh_ff <= x_ff[XL-1:0] * x_ff[X_W-1:XL];
         phh_ff <= x_ff[X_W-1:XL] * x_ff[X_W-1:XL];
         xq_ff  <= xs_ff;
         x2_ff  <= x2_in;
      end
   end

   assign out_ctrl = ctlq_ff;
   assign out_x    = xq_ff;
   assign out_x2   = x2_ff;

endmodule

/* design/tscu_term_cell.sv */
// One cell of the series chain: next term = round(round(t*x^2) / factorial
// step), and the signed sum of terms so far. Five register stages.
// Depends on tscu_pkg.
module tscu_term_cell #(
   parameter int TERM   = 1,
   parameter bit COSINE = 1'b0
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic [tscu_pkg::X2_W-1:0]          x2_i,
   input  logic [tscu_pkg::T_W-1:0]           t_i,
   input  logic signed [tscu_pkg::SUM_W-1:0]  sum_i,
   output logic [tscu_pkg::X2_W-1:0]          x2_o,
   output logic [tscu_pkg::T_W-1:0]           t_o,
   output logic signed [tscu_pkg::SUM_W-1:0]  sum_o
);

   localparam int X2_W  = tscu_pkg::X2_W;
   localparam int T_W   = tscu_pkg::T_W;
   localparam int SUM_W = tscu_pkg::SUM_W;
   localparam int N_W   = tscu_pkg::N_W;
   localparam int M_W   = tscu_pkg::M_W;
   localparam int WB    = tscu_pkg::WORK_BITS;
   localparam int RS    = tscu_pkg::RECIP_SHIFT;

   // Factorial step, its half for rounding, and its reciprocal
   localparam int D    = COSINE ? (2 * TERM) * (2 * TERM - 1) : (2 * TERM) * (2 * TERM + 1);
   localparam int HALF = D / 2;
   localparam logic [63:0] RECIP64 = (64'd1 << RS) / 64'(D);
   localparam logic [M_W-1:0] RECIP = RECIP64[M_W-1:0];
   // Sign of the term this cell adds
   localparam bit NEG = COSINE ? (TERM % 2 == 1) : (TERM % 2 == 0);

   localparam int TL = T_W / 2;
   localparam int TH = T_W - TL;
   localparam int YL = X2_W / 2;
   localparam int YH = X2_W - YL;
   localparam int FULL_W = T_W + X2_W;
   localparam int NL = N_W / 2;
   localparam int NH = N_W - NL;
   localparam int ML = M_W / 2;
   localparam int MH = M_W - ML;
   localparam int PROD_W = N_W + M_W;
   localparam int Q_W = PROD_W - RS;

   // Stage 1: partial products of t*x^2
   logic [TL+YL-1:0]        p00_ff;
   logic [TL+YH-1:0]        p01_ff;
   logic [TH+YL-1:0]        p10_ff;
   logic [TH+YH-1:0]        p11_ff;
   logic [X2_W-1:0]         x2_1_ff;
   logic signed [SUM_W-1:0] sum_1_ff;
   logic signed [SUM_W-1:0] sum_1_in;
   // Stage 2: rounded product plus half the divisor
   logic [N_W-1:0]          n_2_ff;
   logic [N_W-1:0]          n_2_in;
   logic [X2_W-1:0]         x2_2_ff;
   logic signed [SUM_W-1:0] sum_2_ff;
   // Stage 3: partial products of n*reciprocal
   logic [NL+ML-1:0]        r00_ff;
   logic [NL+MH-1:0]        r01_ff;
   logic [NH+ML-1:0]        r10_ff;
   logic [NH+MH-1:0]        r11_ff;
   logic [N_W-1:0]          n_3_ff;
   logic [X2_W-1:0]         x2_3_ff;
   logic signed [SUM_W-1:0] sum_3_ff;
   // Stage 4: estimated quotient
   logic [Q_W-1:0]          q0_4_ff;
   logic [Q_W-1:0]          q0_4_in;
   logic [N_W-1:0]          n_4_ff;
   logic [X2_W-1:0]         x2_4_ff;
   logic signed [SUM_W-1:0] sum_4_ff;
   // Stage 5: corrected quotient and sum
   logic [T_W-1:0]          t_5_ff;
   logic [T_W-1:0]          t_5_in;
   logic [X2_W-1:0]         x2_5_ff;
   logic signed [SUM_W-1:0] sum_5_ff;
   logic signed [SUM_W-1:0] sum_5_in;

   // Sine adds the incoming term
   always_comb begin
      logic signed [SUM_W-1:0] ts;
      ts = $signed({1'b0, t_i});
      if (COSINE) begin
         sum_1_in = sum_i;
      end else begin
         sum_1_in = NEG ? (sum_i - ts) : (sum_i + ts);
      end
   end

   // Combine and round t*x^2, add half the divisor
   always_comb begin
      logic [FULL_W:0] full;
      full = (FULL_W+1)'(p00_ff) + ((FULL_W+1)'(p01_ff) << YL)
           + ((FULL_W+1)'(p10_ff) << TL) + ((FULL_W+1)'(p11_ff) << (TL + YL))
           + ((FULL_W+1)'(1) << (WB - 1));
      n_2_in = full[WB +: N_W] + N_W'(HALF);
   end

   // Combine n*reciprocal; the estimate is low by at most one
   always_comb begin
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(r00_ff) + (PROD_W'(r01_ff) << ML)
           + (PROD_W'(r10_ff) << NL) + (PROD_W'(r11_ff) << (NL + ML));
      q0_4_in = prod[RS +: Q_W];
   end

   // Correct the estimate; cosine adds the new term
   always_comb begin
      logic [N_W-1:0]          rem;
      logic [Q_W-1:0]          q;
      logic signed [SUM_W-1:0] ts;
      rem = n_4_ff - N_W'(q0_4_ff) * N_W'(D);
      q   = (rem >= N_W'(D)) ? q0_4_ff + Q_W'(1) : q0_4_ff;
      t_5_in = q[T_W-1:0];
      ts = $signed({1'b0, t_5_in});
      if (COSINE) begin
         sum_5_in = NEG ? (sum_4_ff - ts) : (sum_4_ff + ts);
      end else begin
         sum_5_in = sum_4_ff;
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff   <= t_i[TL-1:0]   * x2_i[YL-1:0];
         p01_ff   <= t_i[TL-1:0]   * x2_i[X2_W-1:YL];
         p10_ff   <= t_i[T_W-1:TL] * x2_i[YL-1:0];
         p11_ff   <= t_i[T_W-1:TL] * x2_i[X2_W-1:YL];
         x2_1_ff  <= x2_i;
         sum_1_ff <= sum_1_in;

         n_2_ff   <= n_2_in;
         x2_2_ff  <= x2_1_ff;
         sum_2_ff <= sum_1_ff;

         r00_ff   <= n_2_ff[NL-1:0]   * RECIP[ML-1:0];
         r01_ff   <= n_2_ff[NL-1:0]   * RECIP[M_W-1:ML];
         r10_ff   <= n_2_ff[N_W-1:NL] * RECIP[ML-1:0];
         r11_ff   <= n_2_ff[N_W-1:NL] * RECIP[M_W-1:ML];
         n_3_ff   <= n_2_ff;
         x2_3_ff  <= x2_2_ff;
         sum_3_ff <= sum_2_ff;

         q0_4_ff  <= q0_4_in;
         n_4_ff   <= n_3_ff;
         x2_4_ff  <= x2_3_ff;
         sum_4_ff <= sum_3_ff;

         t_5_ff   <= t_5_in;
         x2_5_ff  <= x2_4_ff;
         sum_5_ff <= sum_5_in;
      end
   end

   assign x2_o  = x2_5_ff;
   assign t_o   = t_5_ff;
   assign sum_o = sum_5_ff;

endmodule

/* design/tscu_div_cell.sv */
// One cell of the tangent divider: a restoring step that settles one
// quotient bit and hands remainder, divisor and quotient on.
// Depends on tscu_pkg.
module tscu_div_cell #(
   parameter int STEP = 0
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [tscu_pkg::DIV_W-1:0]    rem_i,
   input  logic [tscu_pkg::SUM_W-1:0]    den_i,
   input  logic [tscu_pkg::QUO_W-1:0]    quo_i,
   output logic [tscu_pkg::DIV_W-1:0]    rem_o,
   output logic [tscu_pkg::SUM_W-1:0]    den_o,
   output logic [tscu_pkg::QUO_W-1:0]    quo_o
);

   localparam int DIV_W = tscu_pkg::DIV_W;
   localparam int QUO_W = tscu_pkg::QUO_W;

   logic [DIV_W-1:0]          rem_ff;
   logic [DIV_W-1:0]          rem_in;
   logic [tscu_pkg::SUM_W-1:0] den_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic [QUO_W-1:0]          quo_in;

   // Subtract the shifted divisor where it fits
   always_comb begin
      logic [DIV_W-1:0] sub;
      sub = DIV_W'(den_i) << STEP;
      if (rem_i >= sub) begin
         rem_in = rem_i - sub;
         quo_in = quo_i | (QUO_W'(1) << STEP);
      end else begin
         rem_in = rem_i;
         quo_in = quo_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         quo_ff <= quo_in;
      end
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule
